// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used across the core RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/core/kmshc_pkg.sv -----
// ----------------------------------------------------------------------------
// kmshc_pkg
// Types and constants shared by the key matrix scanner core.
// ----------------------------------------------------------------------------
`default_nettype none

package kmshc_pkg;

    localparam int MASK_W     = 12;
    localparam int TIME_W     = 32;
    localparam int HOLD_W     = 16;
    localparam int KEYIDX_W   = 4;
    localparam int KEYNUM_W   = 4;
    localparam int FLASH_W    = 2;
    localparam int PROG_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [HOLD_W-1:0]   HOLD_TIME_RST  = 16'd2000;
    localparam logic [KEYIDX_W-1:0] FIRST_KEY_RST  = 4'd8;
    localparam logic [KEYIDX_W-1:0] SECOND_KEY_RST = 4'd11;

    localparam logic ITEM_PRESS  = 1'b0;
    localparam logic ITEM_STATUS = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HOLD_TIME  = 2'd0,
        CFG_FIRST_KEY  = 2'd1,
        CFG_SECOND_KEY = 2'd2
    } t_cfg_reg;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_HOLD = 5'b00100,
        S_PROG = 5'b01000,
        S_STAT = 5'b10000
    } t_state;

    typedef struct packed {
        logic                item_kind;
        logic [KEYNUM_W-1:0] key_number;
        logic [FLASH_W-1:0]  flash_led;
        logic                macro_allowed;
        logic [PROG_W-1:0]   progress_leds;
        logic                show_progress;
        logic                enter_menu;
        logic                combo_cancelled;
        logic                last;
    } t_item;

    typedef struct packed {
        logic              done;
        logic              reached;
        logic [PROG_W-1:0] leds;
    } t_prog_res;

endpackage

`default_nettype wire

// ----- rtl/core/kmshc_ifs.sv -----
// ----------------------------------------------------------------------------
// kmshc interfaces
// Valid/ready channels for scan frames, result items and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface kmshc_scan_if;
    logic                            valid;
    logic                            ready;
    logic [kmshc_pkg::MASK_W-1:0]    pressed_mask;
    logic [kmshc_pkg::TIME_W-1:0]    now_ms;

    modport source (output valid, pressed_mask, now_ms, input ready);
    modport sink   (input valid, pressed_mask, now_ms, output ready);
endinterface

interface kmshc_item_if;
    logic                            valid;
    logic                            ready;
    logic                            item_kind;
    logic [kmshc_pkg::KEYNUM_W-1:0]  key_number;
    logic [kmshc_pkg::FLASH_W-1:0]   flash_led;
    logic                            macro_allowed;
    logic [kmshc_pkg::PROG_W-1:0]    progress_leds;
    logic                            show_progress;
    logic                            enter_menu;
    logic                            combo_cancelled;
    logic                            last;

    modport source (output valid, item_kind, key_number, flash_led, macro_allowed,
                    progress_leds, show_progress, enter_menu, combo_cancelled, last,
                    input ready);
    modport sink   (input valid, item_kind, key_number, flash_led, macro_allowed,
                    progress_leds, show_progress, enter_menu, combo_cancelled, last,
                    output ready);
endinterface

interface kmshc_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [kmshc_pkg::CFG_IDX_W-1:0]   index;
    logic [kmshc_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/key_matrix_scanner_with_hold_combo_core.sv -----
// ----------------------------------------------------------------------------
// key_matrix_scanner_with_hold_combo_core
// Emits press events for newly pressed keys and one hold combo status item
// per scan frame.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload                                   Transfer
// i_scan    in   pressed_mask, now_ms                      valid & ready
// o_event   out  item_kind .. last (one result item)       valid & ready
// i_cfg     in   index, data (register write)              valid & ready
//
// A frame passes through the key scan, the hold check, then, while the
// combo is held and not yet fired, one add/compare step per lit LED in the
// progress unit, and last the status item. Output back-pressure stalls
// the key scan only on keys that emit an event. Reset is synchronous; no
// memories, nothing to clear. i_scan is ready only between frames.
// ----------------------------------------------------------------------------
`default_nettype none

module key_matrix_scanner_with_hold_combo_core #(
    parameter int ROWS      = 3,
    parameter int COLS      = 4,
    parameter int LED_COUNT = 4
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    kmshc_scan_if.sink  i_scan,
    kmshc_item_if.source o_event,
    kmshc_cfg_if.sink   i_cfg
);
    import kmshc_pkg::*;

    `include "assert_macros.svh"

    localparam int NKEYS  = ROWS * COLS;
    localparam int SCAN_N = (NKEYS < MASK_W) ? NKEYS : MASK_W;
    localparam int KEY_W  = (SCAN_N > 1) ? $clog2(SCAN_N) : 1;
    localparam int COL_W  = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int LED_W  = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam logic [MASK_W-1:0] KEY_MASK =
        (NKEYS >= MASK_W) ? {MASK_W{1'b1}} : MASK_W'((64'd1 << NKEYS) - 64'd1);

    // registers
    logic [HOLD_W-1:0]   r_hold_time;
    logic [KEYIDX_W-1:0] r_first;
    logic [KEYIDX_W-1:0] r_second;

    t_state              r_state;
    logic [MASK_W-1:0]   r_prev;
    logic [SCAN_N-1:0]   r_newly;
    logic [KEY_W-1:0]    r_key;
    logic [COL_W-1:0]    r_col;
    logic [LED_W-1:0]    r_led;
    logic [TIME_W-1:0]   r_now;
    logic                r_both;
    logic [TIME_W-1:0]   r_start;
    logic                r_active;
    logic                r_fired;
    t_item               r_stat;
    t_item               r_out;
    logic                r_out_valid;

    logic                w_accept;
    logic [MASK_W-1:0]   w_frame;
    logic [15:0]         w_frame_x;
    logic                w_held1;
    logic                w_held2;
    logic                w_out_free;
    logic                w_scan_step;
    logic                w_scan_end;
    logic                w_evt_load;
    logic                w_stat_load;
    logic                w_prog_start;
    logic [TIME_W-1:0]   w_elapsed;
    logic [HOLD_W-1:0]   w_limit;
    t_prog_res           w_prog;

    assign i_cfg.ready  = 1'b1;
    assign i_scan.ready = (r_state == S_IDLE);
    assign w_accept     = i_scan.valid && i_scan.ready;

    assign w_frame   = i_scan.pressed_mask & KEY_MASK;
    assign w_frame_x = {{(16 - MASK_W){1'b0}}, w_frame};
    assign w_held1   = (int'(r_first) < NKEYS) && w_frame_x[r_first];
    assign w_held2   = (int'(r_second) < NKEYS) && w_frame_x[r_second];

    assign w_out_free   = !r_out_valid || o_event.ready;
    assign w_scan_step  = (r_state == S_SCAN) && (!r_newly[0] || w_out_free);
    assign w_scan_end   = (r_key == KEY_W'(SCAN_N - 1));
    assign w_evt_load   = w_scan_step && r_newly[0];
    assign w_stat_load  = (r_state == S_STAT) && w_out_free;
    assign w_prog_start = (r_state == S_HOLD) && r_both && !r_fired;
    assign w_elapsed    = r_now - (r_active ? r_start : r_now);
    assign w_limit      = (r_hold_time == '0) ? HOLD_W'(1) : r_hold_time;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_time <= HOLD_TIME_RST;
            r_first     <= FIRST_KEY_RST;
            r_second    <= SECOND_KEY_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_HOLD_TIME:  r_hold_time <= i_cfg.data;
                CFG_FIRST_KEY:  r_first     <= i_cfg.data[KEYIDX_W-1:0];
                CFG_SECOND_KEY: r_second    <= i_cfg.data[KEYIDX_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer and hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_prev   <= '0;
            r_start  <= '0;
            r_active <= 1'b0;
            r_fired  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_prev  <= w_frame;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (w_scan_step && w_scan_end) begin
                        r_state <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    if (r_both) begin
                        if (!r_fired) begin
                            if (!r_active) begin
                                r_start  <= r_now;
                                r_active <= 1'b1;
                            end
                            r_state <= S_PROG;
                        end else begin
                            r_state <= S_STAT;
                        end
                    end else begin
                        r_start  <= '0;
                        r_active <= 1'b0;
                        r_fired  <= 1'b0;
                        r_state  <= S_STAT;
                    end
                end
                S_PROG: begin
                    if (w_prog.done) begin
                        if (w_prog.reached) begin
                            r_fired <= 1'b1;
                        end
                        r_state <= S_STAT;
                    end
                end
                S_STAT: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // frame payload and key position counters
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_newly <= SCAN_N'(w_frame & ~r_prev);
            r_now   <= i_scan.now_ms;
            r_both  <= w_held1 && w_held2;
            r_key   <= '0;
            r_col   <= '0;
            r_led   <= '0;
        end else if (w_scan_step) begin
            r_newly <= r_newly >> 1;
            r_key   <= r_key + KEY_W'(1);
            if (r_col == COL_W'(COLS - 1)) begin
                r_col <= '0;
                r_led <= '0;
            end else begin
                r_col <= r_col + COL_W'(1);
                r_led <= (r_led == LED_W'(LED_COUNT - 1)) ? '0 : r_led + LED_W'(1);
            end
        end
    end

    // status item contents
    always_ff @(posedge i_clk) begin
        if (r_state == S_HOLD) begin
            r_stat                 <= '0;
            r_stat.item_kind       <= ITEM_STATUS;
            r_stat.last            <= 1'b1;
            r_stat.combo_cancelled <= !r_both && r_active && !r_fired;
        end else if ((r_state == S_PROG) && w_prog.done) begin
            r_stat.progress_leds <= w_prog.leds;
            r_stat.show_progress <= 1'b1;
            r_stat.enter_menu    <= w_prog.reached;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_evt_load || w_stat_load) begin
            r_out_valid <= 1'b1;
        end else if (o_event.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_evt_load) begin
            r_out               <= '0;
            r_out.item_kind     <= ITEM_PRESS;
            r_out.key_number    <= KEYNUM_W'(r_key) + KEYNUM_W'(1);
            r_out.flash_led     <= FLASH_W'(r_led);
            r_out.macro_allowed <= !r_active;
        end else if (w_stat_load) begin
            r_out <= r_stat;
        end
    end

    kmshc_prog #(
        .LED_COUNT(LED_COUNT)
    ) u_prog (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_prog_start),
        .i_elapsed (w_elapsed),
        .i_limit   (w_limit),
        .o_res     (w_prog)
    );

    assign o_event.valid           = r_out_valid;
    assign o_event.item_kind       = r_out.item_kind;
    assign o_event.key_number      = r_out.key_number;
    assign o_event.flash_led       = r_out.flash_led;
    assign o_event.macro_allowed   = r_out.macro_allowed;
    assign o_event.progress_leds   = r_out.progress_leds;
    assign o_event.show_progress   = r_out.show_progress;
    assign o_event.enter_menu      = r_out.enter_menu;
    assign o_event.combo_cancelled = r_out.combo_cancelled;
    assign o_event.last            = r_out.last;

    `ASSERT_IMP(a_fired_needs_active, i_clk, i_rst_n, r_fired, r_active)
    `ASSERT_IMP(a_idle_no_event_left, i_clk, i_rst_n, (r_state == S_IDLE) && r_out_valid, r_out.last)
    `ASSERT_IMP(a_prog_done_in_prog, i_clk, i_rst_n, w_prog.done, r_state == S_PROG)
    `ASSERT_IMP(a_enter_not_cancel, i_clk, i_rst_n, r_out_valid, !(r_out.enter_menu && r_out.combo_cancelled))
    `ASSERT_NXT(a_accept_starts_scan, i_clk, i_rst_n, w_accept, r_state == S_SCAN)

endmodule

`default_nettype wire

// ----- rtl/core/kmshc_prog.sv -----
// ----------------------------------------------------------------------------
// kmshc_prog
// Hold progress unit: counts how many multiples of the hold time fit in
// elapsed * LED_COUNT, one add and compare per cycle, saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module kmshc_prog #(
    parameter int LED_COUNT = 4
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic [kmshc_pkg::TIME_W-1:0]    i_elapsed,
    input  wire logic [kmshc_pkg::HOLD_W-1:0]    i_limit,
    output kmshc_pkg::t_prog_res                 o_res
);
    import kmshc_pkg::*;

    localparam int LIT_W  = $clog2(LED_COUNT + 1);
    localparam int PROD_W = TIME_W + LIT_W;
    localparam int ACC_W  = HOLD_W + LIT_W;

    logic              r_busy;
    logic              r_done;
    logic [PROD_W-1:0] r_prod;
    logic [ACC_W-1:0]  r_acc;
    logic [LIT_W-1:0]  r_lit;
    logic              w_more;

    assign w_more = (r_lit != LIT_W'(LED_COUNT)) && (r_prod >= PROD_W'(r_acc));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
            end else if (r_busy && !w_more) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_prod <= PROD_W'(i_elapsed) * PROD_W'(LED_COUNT);
            r_acc  <= ACC_W'(i_limit);
            r_lit  <= '0;
        end else if (r_busy && w_more) begin
            r_acc <= r_acc + ACC_W'(i_limit);
            r_lit <= r_lit + LIT_W'(1);
        end
    end

    assign o_res.done    = r_done;
    assign o_res.reached = (r_lit == LIT_W'(LED_COUNT));
    assign o_res.leds    = PROG_W'(r_lit);

endmodule

`default_nettype wire

// ----- bench/key_matrix_scanner_with_hold_combo_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_matrix_scanner_with_hold_combo_core_tb
// Drives scan frames and register writes into the scanner core. A tracker
// class keeps its own copy of the key and hold combo state and predicts the
// press events and the status item of every frame. Each returned item is
// compared field by field, with random gaps on the scan side and random
// back-pressure on the result side.
// ----------------------------------------------------------------------------

module key_matrix_scanner_with_hold_combo_core_tb;

    import kmshc_pkg::*;

    localparam int ROWS        = 3;
    localparam int COLS        = 4;
    localparam int LED_COUNT   = 4;
    localparam int NKEYS       = ROWS * COLS;
    localparam int SETTLE_CYC  = 40;
    localparam int PHASE_ITEMS = 29;

    class press_combo_tracker;
        logic [HOLD_W-1:0]   hold_time;
        logic [KEYIDX_W-1:0] first_key;
        logic [KEYIDX_W-1:0] second_key;
        logic [MASK_W-1:0]   prev_keys;
        logic [TIME_W-1:0]   hold_start;
        bit                  hold_active;
        bit                  hold_fired;
        t_item               pending_items[$];
        int unsigned         mismatches;

        function new();
            hold_time   = HOLD_TIME_RST;
            first_key   = FIRST_KEY_RST;
            second_key  = SECOND_KEY_RST;
            prev_keys   = '0;
            hold_start  = '0;
            hold_active = 1'b0;
            hold_fired  = 1'b0;
            mismatches  = 0;
        endfunction

        function void write_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_HOLD_TIME:  hold_time  = val[HOLD_W-1:0];
                CFG_FIRST_KEY:  first_key  = val[KEYIDX_W-1:0];
                CFG_SECOND_KEY: second_key = val[KEYIDX_W-1:0];
                default: ;
            endcase
        endfunction

        function bit key_down(logic [MASK_W-1:0] frame, logic [KEYIDX_W-1:0] idx);
            return (idx < NKEYS) ? frame[idx] : 1'b0;
        endfunction

        function void note_frame(logic [MASK_W-1:0] frame, logic [TIME_W-1:0] now);
            t_item             it;
            logic [MASK_W-1:0] fresh;
            logic [TIME_W-1:0] elapsed;
            bit [63:0]         lit;
            bit [63:0]         limit;
            fresh = frame & ~prev_keys;
            for (int i = 0; i < NKEYS; i++) begin
                if (fresh[i]) begin
                    it               = '0;
                    it.item_kind     = ITEM_PRESS;
                    it.key_number    = KEYNUM_W'(i + 1);
                    it.flash_led     = FLASH_W'((i % COLS) % LED_COUNT);
                    it.macro_allowed = !hold_active;
                    pending_items.push_back(it);
                end
            end
            prev_keys = frame;
            it           = '0;
            it.item_kind = ITEM_STATUS;
            it.last      = 1'b1;
            if (key_down(frame, first_key) && key_down(frame, second_key)) begin
                if (!hold_fired) begin
                    limit = (hold_time == 0) ? 64'd1 : 64'(hold_time);
                    if (!hold_active) begin
                        hold_start  = now;
                        hold_active = 1'b1;
                    end
                    elapsed = now - hold_start;
                    lit = (64'(elapsed) * 64'(LED_COUNT)) / limit;
                    if (lit > 64'(LED_COUNT))
                        lit = 64'(LED_COUNT);
                    it.progress_leds = PROG_W'(lit);
                    it.show_progress = 1'b1;
                    if (64'(elapsed) >= limit) begin
                        hold_fired    = 1'b1;
                        it.enter_menu = 1'b1;
                    end
                end
            end else begin
                it.combo_cancelled = hold_active && !hold_fired;
                hold_start  = '0;
                hold_active = 1'b0;
                hold_fired  = 1'b0;
            end
            pending_items.push_back(it);
        endfunction

        function void cmp_field(string name, int unsigned exp_v, int unsigned got_v);
            if (exp_v != got_v) begin
                $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, got_v);
                mismatches++;
            end
        endfunction

        function void check_item(t_item got);
            t_item exp_it;
            if (pending_items.size() == 0) begin
                $display("%0t: unexpected item, expected none, got %h", $time, got);
                mismatches++;
                return;
            end
            exp_it = pending_items.pop_front();
            cmp_field("item_kind", exp_it.item_kind, got.item_kind);
            cmp_field("key_number", exp_it.key_number, got.key_number);
            cmp_field("flash_led", exp_it.flash_led, got.flash_led);
            cmp_field("macro_allowed", exp_it.macro_allowed, got.macro_allowed);
            cmp_field("progress_leds", exp_it.progress_leds, got.progress_leds);
            cmp_field("show_progress", exp_it.show_progress, got.show_progress);
            cmp_field("enter_menu", exp_it.enter_menu, got.enter_menu);
            cmp_field("combo_cancelled", exp_it.combo_cancelled, got.combo_cancelled);
            cmp_field("last", exp_it.last, got.last);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   no_idle;

    logic [TIME_W-1:0] now_ms;

    press_combo_tracker sb = new();

    kmshc_scan_if scan_if ();
    kmshc_item_if item_if ();
    kmshc_cfg_if  cfg_if ();

    key_matrix_scanner_with_hold_combo_core #(
        .ROWS      (ROWS),
        .COLS      (COLS),
        .LED_COUNT (LED_COUNT)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_scan  (scan_if),
        .o_event (item_if),
        .i_cfg   (cfg_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result side back-pressure
    initial begin
        int unsigned stall;
        stall = 0;
        item_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall > 0) begin
                item_if.ready <= 1'b0;
                stall--;
            end else begin
                item_if.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        t_item got;
        if (i_rst_n && item_if.valid && item_if.ready) begin
            got.item_kind       = item_if.item_kind;
            got.key_number      = item_if.key_number;
            got.flash_led       = item_if.flash_led;
            got.macro_allowed   = item_if.macro_allowed;
            got.progress_leds   = item_if.progress_leds;
            got.show_progress   = item_if.show_progress;
            got.enter_menu      = item_if.enter_menu;
            got.combo_cancelled = item_if.combo_cancelled;
            got.last            = item_if.last;
            sb.check_item(got);
        end
    end

    task automatic send_frame(input logic [MASK_W-1:0] mask, input logic [TIME_W-1:0] now);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            scan_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        scan_if.valid        <= 1'b1;
        scan_if.pressed_mask <= mask;
        scan_if.now_ms       <= now;
        @(posedge i_clk);
        while (!scan_if.ready) @(posedge i_clk);
        sb.note_frame(mask, now);
    endtask

    task automatic wait_results_done();
        scan_if.valid <= 1'b0;
        while (sb.pending_items.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        sb.write_reg(idx, val);
    endtask

    // upper data bits are random; only the low bits land in the key registers
    task automatic set_config(input logic [HOLD_W-1:0] hold,
                              input logic [KEYIDX_W-1:0] k1,
                              input logic [KEYIDX_W-1:0] k2);
        write_reg(CFG_HOLD_TIME, hold);
        write_reg(CFG_FIRST_KEY, {12'($urandom), k1});
        write_reg(CFG_SECOND_KEY, {12'($urandom), k2});
        cfg_if.valid <= 1'b0;
    endtask

    function automatic logic [TIME_W-1:0] time_step();
        int unsigned lim;
        lim = (sb.hold_time == 0) ? 32'd1 : 32'(sb.hold_time);
        if ($urandom_range(0, 19) == 0)
            return $urandom;
        return $urandom_range(0, lim / 2 + 1);
    endfunction

    function automatic logic [MASK_W-1:0] rand_mask();
        if ($urandom_range(0, 1) == 0)
            return MASK_W'($urandom);
        return MASK_W'($urandom & $urandom & $urandom);
    endfunction

    function automatic logic [MASK_W-1:0] key_bit(logic [KEYIDX_W-1:0] idx);
        return (idx < NKEYS) ? MASK_W'(1) << idx : '0;
    endfunction

    task automatic run_phase(input int n);
        int sent;
        int hold_len;
        int unsigned rel;
        logic [MASK_W-1:0] combo;
        logic [MASK_W-1:0] drop;
        sent  = 0;
        combo = key_bit(sb.first_key) | key_bit(sb.second_key);
        while (sent < n) begin
            if ($urandom_range(0, 9) < 7) begin
                hold_len = $urandom_range(1, 8);
                for (int k = 0; k < hold_len && sent < n; k++) begin
                    now_ms += time_step();
                    send_frame(rand_mask() | combo, now_ms);
                    sent++;
                end
                rel  = $urandom_range(1, 3);
                drop = (rel[0] ? key_bit(sb.first_key) : '0)
                     | (rel[1] ? key_bit(sb.second_key) : '0);
                now_ms += time_step();
                send_frame(rand_mask() & ~drop, now_ms);
                sent++;
            end else begin
                now_ms += time_step();
                send_frame(MASK_W'($urandom), now_ms);
                sent++;
            end
        end
    endtask

    initial begin
        logic [KEYIDX_W-1:0] ka;
        logic [KEYIDX_W-1:0] kb;
        i_rst_n              = 1'b0;
        no_idle              = 1'b0;
        scan_if.valid        = 1'b0;
        scan_if.pressed_mask = '0;
        scan_if.now_ms       = '0;
        cfg_if.valid         = 1'b0;
        cfg_if.index         = CFG_HOLD_TIME;
        cfg_if.data          = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: hold 2000 ms on keys 8 and 11
        send_frame(12'h000, 32'd0);
        send_frame(12'hFFF, 32'd100);
        send_frame(12'hFFF, 32'd600);
        send_frame(12'h000, 32'd700);
        send_frame(12'h900, 32'd1000);
        send_frame(12'h900, 32'd3000);
        send_frame(12'h901, 32'd3500);
        send_frame(12'h000, 32'd3600);
        // timestamp wrap during a hold, then early release
        send_frame(12'h900, 32'hFFFF_FF00);
        send_frame(12'h900, 32'h0000_0300);
        send_frame(12'h100, 32'h0000_0400);
        wait_results_done();

        // zero hold time, both combo indices on one key
        set_config(16'd0, 4'd5, 4'd5);
        send_frame(12'h020, 32'h8000_0000);
        send_frame(12'h020, 32'h8000_0001);
        send_frame(12'h7FF, 32'h8000_0002);
        send_frame(12'h000, 32'h8000_0003);
        wait_results_done();

        // combo keys beyond the matrix
        set_config(16'hFFFF, 4'd12, 4'd15);
        send_frame(12'hFFF, 32'h5555_5555);
        send_frame(12'h000, 32'hAAAA_AAAA);
        wait_results_done();

        set_config(16'd1, 4'd0, 4'd11);
        send_frame(12'h801, 32'd5);
        send_frame(12'h803, 32'd6);
        send_frame(12'h001, 32'd7);
        send_frame(12'hFFF, 32'd8);
        send_frame(12'hFFF, 32'hFFFF_FFFF);
        send_frame(12'h000, 32'd9);
        wait_results_done();

        for (int p = 0; p < 8; p++) begin
            ka = KEYIDX_W'($urandom_range(0, NKEYS - 1));
            kb = KEYIDX_W'($urandom_range(0, NKEYS - 1));
            case (p)
                0: set_config(16'hFFFF, ka, kb);
                1: set_config(16'd1, ka, kb);
                2: set_config(16'd0, ka, kb);
                3: set_config(HOLD_W'($urandom_range(1, 200)), ka, kb);
                4: set_config(HOLD_W'($urandom_range(1, 65535)), ka, ka);
                5: set_config(HOLD_W'($urandom_range(1, 5000)), ka,
                              KEYIDX_W'($urandom_range(NKEYS, 15)));
                default: set_config(HOLD_W'($urandom_range(20, 3000)), ka, kb);
            endcase
            no_idle = (p == 3);
            now_ms  = $urandom;
            run_phase(PHASE_ITEMS);
            wait_results_done();
        end
        no_idle = 1'b0;

        if (sb.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- key_matrix_scanner_with_hold_combo_core.f -----
+incdir+rtl/core
rtl/core/kmshc_pkg.sv
rtl/core/kmshc_ifs.sv
rtl/core/kmshc_prog.sv
rtl/core/key_matrix_scanner_with_hold_combo_core.sv
bench/key_matrix_scanner_with_hold_combo_core_tb.sv
